[hdl/akvt_pkg.sv]
package akvt_pkg;

  localparam int CMD_W = 2;
  localparam int KEY_W = 32;
  localparam int VAL_W = 16;
  localparam int CNT_W = 7;
  localparam int CFG_W = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_SET    = 2'd1,
    CMD_DECAY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  localparam logic [CFG_ADDR_W-1:0] CFG_SET_LEVEL   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FLOOR_LEVEL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DECAY = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic key_we;
    logic lvl_we;
  } mem_ctl_t;

endpackage

[hdl/akvt_mem.sv]
module akvt_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int KSW   = 32,
  parameter int LB    = 16
) (
  input  logic                 clk,
  input  akvt_pkg::mem_ctl_t   ctl,
  input  logic [AW-1:0]        rd_addr,
  input  logic [AW-1:0]        wr_addr,
  input  logic [KSW-1:0]       wr_key,
  input  logic signed [LB-1:0] wr_lvl,
  output logic [KSW-1:0]       rd_key,
  output logic signed [LB-1:0] rd_lvl
);

  logic [KSW-1:0]       key_mem_r [DEPTH];
  logic signed [LB-1:0] lvl_mem_r [DEPTH];
  logic [KSW-1:0]       rd_key_r;
  logic signed [LB-1:0] rd_lvl_r;

  always_ff @(posedge clk) begin
    if (ctl.key_we) begin
      key_mem_r[wr_addr] <= wr_key;
    end
    if (ctl.lvl_we) begin
      lvl_mem_r[wr_addr] <= wr_lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_key_r <= key_mem_r[rd_addr];
      rd_lvl_r <= lvl_mem_r[rd_addr];
    end
  end

  assign rd_key = rd_key_r;
  assign rd_lvl = rd_lvl_r;

endmodule

[hdl/aging_key_value_table.sv]
// Lookup and set scan the stored entries at one entry per cycle, ending early when the key is
// found; with an empty table each command goes straight to the response state. Decay scans
// every stored entry; clear does not scan. One request is in work at a time, as in_tready is
// high only in idle, and the next is taken in the cycle after the result is registered.
// Reset (rst_n low, synchronous) empties the table and loads set_level 8 and floor_level 0.
// Since keys are only ever added at the next free slot, the stored count marks valid entries.
module aging_key_value_table #(
  parameter int CAPACITY   = 64,
  parameter int KEY_ELEMS  = 4,
  parameter int LEVEL_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [akvt_pkg::KEY_W-1:0]       in_tdata,   // key
  input  logic [akvt_pkg::CMD_W-1:0]       in_tuser,   // command
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [akvt_pkg::OUT_DATA_W-1:0]  out_tdata,  // found, value, entry_count, dropped
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [akvt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [akvt_pkg::CFG_W-1:0]       cfg_data
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int KW  = KEY_ELEMS * 8;
  localparam int KSW = (KW < akvt_pkg::KEY_W) ? KW : akvt_pkg::KEY_W;
  localparam int LB  = LEVEL_BITS;
  localparam int DW  = ((LB > akvt_pkg::CFG_W) ? LB : akvt_pkg::CFG_W) + 2;
  localparam logic signed [DW-1:0] LMAX = DW'((64'sd1 <<< (LB - 1)) - 64'sd1);
  localparam logic signed [DW-1:0] LMIN = -LMAX - DW'(1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  function automatic logic signed [LB-1:0] sat_lvl(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] s;
    s = v;
    if (v < LMIN) begin
      s = LMIN;
    end else if (v > LMAX) begin
      s = LMAX;
    end
    return s[LB-1:0];
  endfunction

  function automatic logic [akvt_pkg::VAL_W-1:0] out_val(input logic signed [LB-1:0] v);
    logic signed [DW-1:0] e;
    e = DW'(v);
    return e[akvt_pkg::VAL_W-1:0];
  endfunction

  akvt_pkg::state_t      state_r, state_nxt;
  akvt_pkg::cmd_t        cmd_r;
  logic [KSW-1:0]        key_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         iss_r, iss_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]         rd_idx_r;
  logic                  hit_r;
  logic [AW-1:0]         hit_idx_r;
  logic signed [LB-1:0]  hit_lvl_r;
  logic signed [akvt_pkg::CFG_W-1:0] set_level_r, floor_level_r;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [akvt_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  akvt_pkg::mem_ctl_t    mem_ctl;
  logic [AW-1:0]         wr_addr;
  logic signed [LB-1:0]  wr_lvl;
  logic [KSW-1:0]        rd_key;
  logic signed [LB-1:0]  rd_lvl;

  logic                  in_fire, resp_fire, match, last, fin;
  logic signed [DW-1:0]  dec_v;
  logic signed [LB-1:0]  dec_lvl, set_lvl;
  logic                  found, dropped;
  logic [akvt_pkg::VAL_W-1:0] val;
  logic [CW+6:0]         cnt_ext;

  assign in_tready = (state_r == akvt_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign resp_fire = (state_r == akvt_pkg::ST_RESP) && (!out_tvalid_r || out_tready);

  assign match = rd_vld_r && (rd_key == key_r);
  assign last  = rd_vld_r && ((CW'(rd_idx_r) + CW'(1)) == cnt_r);
  assign fin   = ((state_r == akvt_pkg::ST_SCAN) && (match || last)) ||
                 ((state_r == akvt_pkg::ST_DECAY) && last);

  assign dec_v   = ((DW'(rd_lvl) - DW'(1)) < DW'(floor_level_r)) ?
                   DW'(floor_level_r) : (DW'(rd_lvl) - DW'(1));
  assign dec_lvl = sat_lvl(dec_v);
  assign set_lvl = sat_lvl(DW'(set_level_r));

  always_comb begin
    mem_ctl.rd_en  = ((state_r == akvt_pkg::ST_SCAN) || (state_r == akvt_pkg::ST_DECAY)) &&
                     (iss_r < cnt_r) && !fin;
    mem_ctl.key_we = 1'b0;
    mem_ctl.lvl_we = 1'b0;
    wr_addr        = rd_idx_r;
    wr_lvl         = dec_lvl;
    found          = 1'b0;
    dropped        = 1'b0;
    val            = '0;
    cnt_nxt        = cnt_r;
    if ((state_r == akvt_pkg::ST_DECAY) && rd_vld_r) begin
      mem_ctl.lvl_we = 1'b1;
    end
    unique case (cmd_r)
      akvt_pkg::CMD_LOOKUP: begin
        found = hit_r;
        val   = hit_r ? out_val(hit_lvl_r) : '1;
      end
      akvt_pkg::CMD_SET: begin
        found = hit_r;
        if (hit_r) begin
          val = out_val(set_lvl);
          if (resp_fire) begin
            mem_ctl.lvl_we = 1'b1;
            wr_addr        = hit_idx_r;
            wr_lvl         = set_lvl;
          end
        end else if (cnt_r < CAP_C) begin
          val = out_val(set_lvl);
          if (resp_fire) begin
            mem_ctl.key_we = 1'b1;
            mem_ctl.lvl_we = 1'b1;
            wr_addr        = cnt_r[AW-1:0];
            wr_lvl         = set_lvl;
            cnt_nxt        = cnt_r + CW'(1);
          end
        end else begin
          dropped = 1'b1;
          val     = '1;
        end
      end
      akvt_pkg::CMD_DECAY: begin
        val = '0;
      end
      akvt_pkg::CMD_CLEAR: begin
        if (resp_fire) begin
          cnt_nxt = '0;
        end
      end
      default: begin
        val = '0;
      end
    endcase
  end

  always_comb begin
    cnt_ext = (CW + 7)'(cnt_nxt);
    out_tdata_nxt = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    if (resp_fire) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = akvt_pkg::OUT_DATA_W'({dropped, cnt_ext[akvt_pkg::CNT_W-1:0], val, found});
    end
  end

  always_comb begin
    state_nxt  = state_r;
    iss_nxt    = mem_ctl.rd_en ? (iss_r + CW'(1)) : iss_r;
    rd_vld_nxt = mem_ctl.rd_en;
    unique case (state_r)
      akvt_pkg::ST_IDLE: begin
        iss_nxt = '0;
        if (in_fire) begin
          if (cnt_r == '0) begin
            state_nxt = akvt_pkg::ST_RESP;
          end else begin
            unique case (akvt_pkg::cmd_t'(in_tuser))
              akvt_pkg::CMD_LOOKUP, akvt_pkg::CMD_SET: state_nxt = akvt_pkg::ST_SCAN;
              akvt_pkg::CMD_DECAY: state_nxt = akvt_pkg::ST_DECAY;
              akvt_pkg::CMD_CLEAR: state_nxt = akvt_pkg::ST_RESP;
              default: state_nxt = akvt_pkg::ST_RESP;
            endcase
          end
        end
      end
      akvt_pkg::ST_SCAN, akvt_pkg::ST_DECAY: begin
        if (fin) begin
          state_nxt = akvt_pkg::ST_RESP;
        end
      end
      akvt_pkg::ST_RESP: begin
        if (resp_fire) begin
          state_nxt = akvt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = akvt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= akvt_pkg::ST_IDLE;
      cnt_r         <= '0;
      iss_r         <= '0;
      rd_vld_r      <= 1'b0;
      out_tvalid_r  <= 1'b0;
      set_level_r   <= 16'sd8;
      floor_level_r <= 16'sd0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      iss_r        <= iss_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid) begin
        unique case (cfg_addr)
          akvt_pkg::CFG_SET_LEVEL:   set_level_r   <= cfg_data;
          akvt_pkg::CFG_FLOOR_LEVEL: floor_level_r <= cfg_data;
          default: set_level_r <= set_level_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    if (mem_ctl.rd_en) begin
      rd_idx_r <= iss_r[AW-1:0];
    end
    if (in_fire) begin
      cmd_r <= akvt_pkg::cmd_t'(in_tuser);
      key_r <= in_tdata[KSW-1:0];
      hit_r <= 1'b0;
    end else if ((state_r == akvt_pkg::ST_SCAN) && match) begin
      hit_r     <= 1'b1;
      hit_idx_r <= rd_idx_r;
      hit_lvl_r <= rd_lvl;
    end
  end

  akvt_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .KSW   (KSW),
    .LB    (LB)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (iss_r[AW-1:0]),
    .wr_addr (wr_addr),
    .wr_key  (key_r),
    .wr_lvl  (wr_lvl),
    .rd_key  (rd_key),
    .rd_lvl  (rd_lvl)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

[tb/tb_aging_key_value_table.sv]
`timescale 1ns / 1ps

module tb_aging_key_value_table;

  localparam int SLOTS = 64;
  localparam int POOL_SIZE = 96;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    akvt_pkg::cmd_t cmd;
    logic [31:0]    key;
  } request_t;

  // Packed from the top bit down, so found lands in bit 0 as on out_tdata.
  typedef struct packed {
    logic               dropped;
    logic [6:0]         count;
    logic signed [15:0] value;
    logic               found;
  } reply_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [akvt_pkg::KEY_W-1:0]      in_tdata;
  logic [akvt_pkg::CMD_W-1:0]      in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [akvt_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [akvt_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [akvt_pkg::CFG_W-1:0]      cfg_data;

  aging_key_value_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  logic               tbl_used [SLOTS];
  logic [31:0]        tbl_key [SLOTS];
  logic signed [15:0] tbl_level [SLOTS];
  int                 tbl_count;
  logic signed [15:0] lvl_set;
  logic signed [15:0] lvl_floor;

  request_t    pending [$];
  reply_t      replies_due [$];
  logic [31:0] key_pool [POOL_SIZE];

  int       errors;
  int       cycle_count;
  logic     in_took;
  logic     out_took;
  bit       in_idle;
  bit       out_idle;
  bit       want_hold;
  bit       hold_taken;
  int       hold_left;
  int       in_wait;
  int       out_wait;
  bit       offer;
  request_t next_req;
  reply_t   want;
  reply_t   got;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic int find_key(logic [31:0] k);
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_used[i] && tbl_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic reply_t predict_reply(akvt_pkg::cmd_t cmd, logic [31:0] k);
    reply_t r;
    int     slot;
    int     lvl;
    r = '0;
    case (cmd)
      akvt_pkg::CMD_LOOKUP: begin
        slot = find_key(k);
        if (slot >= 0) begin
          r.found = 1'b1;
          r.value = tbl_level[slot];
        end else begin
          r.value = -16'sd1;
        end
      end
      akvt_pkg::CMD_SET: begin
        slot = find_key(k);
        if (slot >= 0) begin
          r.found = 1'b1;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot < 0 && !tbl_used[i]) slot = i;
          end
          if (slot >= 0) begin
            tbl_used[slot] = 1'b1;
            tbl_key[slot] = k;
            tbl_count++;
          end
        end
        if (slot >= 0) begin
          tbl_level[slot] = lvl_set;
          r.value = lvl_set;
        end else begin
          r.dropped = 1'b1;
          r.value = -16'sd1;
        end
      end
      akvt_pkg::CMD_DECAY: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_used[i]) begin
            lvl = int'(tbl_level[i]) - 1;
            if (lvl < int'(lvl_floor)) lvl = int'(lvl_floor);
            if (lvl < -32768) lvl = -32768;
            tbl_level[i] = lvl[15:0];
          end
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) tbl_used[i] = 1'b0;
        tbl_count = 0;
      end
    endcase
    r.count = tbl_count[6:0];
    return r;
  endfunction

  function automatic int draw_wait(bit enabled);
    if (!enabled) return 0;
    return $urandom_range(0, 16);
  endfunction

  always @(posedge clk) begin
    in_took <= rst_n && in_tvalid && in_tready;
    out_took <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      replies_due.push_back(predict_reply(akvt_pkg::cmd_t'(in_tuser), in_tdata));
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = reply_t'(out_tdata[24:0]);
      if (replies_due.size() == 0) begin
        flag_mismatch($sformatf("result 0x%08h with no request waiting", out_tdata));
      end else begin
        want = replies_due.pop_front();
        if (got.found !== want.found)
          flag_mismatch($sformatf("found %0b, want %0b", got.found, want.found));
        if (got.value !== want.value)
          flag_mismatch($sformatf("value %0d, want %0d", got.value, want.value));
        if (got.count !== want.count)
          flag_mismatch($sformatf("entry_count %0d, want %0d", got.count, want.count));
        if (got.dropped !== want.dropped)
          flag_mismatch($sformatf("dropped %0b, want %0b", got.dropped, want.dropped));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_wait = 0;
    end else begin
      offer = in_tvalid && !in_took;
      if (!offer) begin
        if (in_wait > 0) begin
          in_wait--;
        end else if (pending.size() != 0) begin
          next_req = pending.pop_front();
          in_tdata <= next_req.key;
          in_tuser <= next_req.cmd;
          in_wait = draw_wait(in_idle);
          offer = 1'b1;
        end
      end
      in_tvalid <= offer;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait = 0;
      hold_left = 0;
    end else begin
      if (want_hold && !hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (out_took) out_wait = draw_wait(out_idle);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic queue_request(input akvt_pkg::cmd_t cmd, input logic [31:0] k);
    request_t req;
    req.cmd = cmd;
    req.key = k;
    pending.push_back(req);
  endtask

  task automatic write_reg(input logic [akvt_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == akvt_pkg::CFG_SET_LEVEL) lvl_set = val;
    else lvl_floor = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (pending.size() != 0 || in_tvalid || replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic akvt_pkg::cmd_t pick_cmd();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 38) return akvt_pkg::CMD_LOOKUP;
    if (roll < 76) return akvt_pkg::CMD_SET;
    if (roll < 95) return akvt_pkg::CMD_DECAY;
    return akvt_pkg::CMD_CLEAR;
  endfunction

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    errors = 0;
    cycle_count = 0;
    in_took = 1'b0;
    out_took = 1'b0;
    in_idle = 1'b0;
    out_idle = 1'b0;
    want_hold = 1'b0;
    hold_taken = 1'b0;
    for (int i = 0; i < SLOTS; i++) tbl_used[i] = 1'b0;
    tbl_count = 0;
    lvl_set = 16'sd8;
    lvl_floor = 16'sd0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(akvt_pkg::CFG_SET_LEVEL, 16'd3);
    write_reg(akvt_pkg::CFG_FLOOR_LEVEL, 16'd0);
    queue_request(akvt_pkg::CMD_LOOKUP, 32'hFFFF_FFFF);
    queue_request(akvt_pkg::CMD_LOOKUP, 32'h0000_0000);
    queue_request(akvt_pkg::CMD_SET, 32'h0000_0000);
    queue_request(akvt_pkg::CMD_SET, 32'hFFFF_FFFF);
    queue_request(akvt_pkg::CMD_SET, 32'h0000_0000);
    queue_request(akvt_pkg::CMD_LOOKUP, 32'h0000_0000);
    queue_request(akvt_pkg::CMD_LOOKUP, 32'hFFFF_FFFF);
    queue_request(akvt_pkg::CMD_LOOKUP, 32'h1234_5678);
    repeat (4) queue_request(akvt_pkg::CMD_DECAY, 32'h0);
    queue_request(akvt_pkg::CMD_LOOKUP, 32'h0000_0000);
    wait_quiet();

    write_reg(akvt_pkg::CFG_SET_LEVEL, 16'h8000);
    write_reg(akvt_pkg::CFG_FLOOR_LEVEL, 16'h7FFF);
    queue_request(akvt_pkg::CMD_SET, 32'hA5A5_A5A5);
    queue_request(akvt_pkg::CMD_DECAY, 32'hFFFF_FFFF);
    queue_request(akvt_pkg::CMD_LOOKUP, 32'hA5A5_A5A5);
    wait_quiet();

    write_reg(akvt_pkg::CFG_SET_LEVEL, 16'h7FFF);
    write_reg(akvt_pkg::CFG_FLOOR_LEVEL, 16'h8000);
    queue_request(akvt_pkg::CMD_SET, 32'h0000_0000);
    queue_request(akvt_pkg::CMD_DECAY, 32'h0);
    queue_request(akvt_pkg::CMD_LOOKUP, 32'h0000_0000);
    wait_quiet();

    write_reg(akvt_pkg::CFG_SET_LEVEL, 16'h8000);
    queue_request(akvt_pkg::CMD_SET, 32'h5A5A_5A5A);
    queue_request(akvt_pkg::CMD_DECAY, 32'h0);
    queue_request(akvt_pkg::CMD_LOOKUP, 32'h5A5A_5A5A);
    queue_request(akvt_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
    queue_request(akvt_pkg::CMD_LOOKUP, 32'h0000_0000);
    queue_request(akvt_pkg::CMD_DECAY, 32'h0);
    wait_quiet();

    // Fill every slot, then offer one key too many.
    in_idle = 1'b1;
    out_idle = 1'b1;
    write_reg(akvt_pkg::CFG_SET_LEVEL, pick_level());
    write_reg(akvt_pkg::CFG_FLOOR_LEVEL, pick_level());
    queue_request(akvt_pkg::CMD_CLEAR, 32'h0);
    for (int i = 0; i < SLOTS; i++) queue_request(akvt_pkg::CMD_SET, key_pool[i]);
    queue_request(akvt_pkg::CMD_SET, key_pool[SLOTS]);
    queue_request(akvt_pkg::CMD_SET, key_pool[3]);
    queue_request(akvt_pkg::CMD_LOOKUP, key_pool[SLOTS]);
    queue_request(akvt_pkg::CMD_LOOKUP, key_pool[10]);
    queue_request(akvt_pkg::CMD_DECAY, 32'h0);
    queue_request(akvt_pkg::CMD_LOOKUP, key_pool[SLOTS - 1]);
    wait_quiet();

    for (int p = 0; p < 6; p++) begin
      write_reg(akvt_pkg::CFG_SET_LEVEL, pick_level());
      write_reg(akvt_pkg::CFG_FLOOR_LEVEL, pick_level());
      in_idle = (p % 3 != 0) && ($urandom_range(0, 3) != 0);
      out_idle = (p % 3 != 0) && ($urandom_range(0, 3) != 0);
      if (p == 2) begin
        in_idle = 1'b0;
        want_hold = 1'b1;
      end
      for (int n = 0; n < 80; n++) queue_request(pick_cmd(), pick_key());
      wait_quiet();
    end

    if (replies_due.size() != 0) flag_mismatch("results still outstanding at the end");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[aging_key_value_table.f]
hdl/akvt_pkg.sv
hdl/akvt_mem.sv
hdl/aging_key_value_table.sv
tb/tb_aging_key_value_table.sv
